// ===== hdl/pws_pkg.sv =====
// ----------------------------------------------------------------------------
// pws_pkg: shared types and constants of the 2x2 weighted solve pipeline
// Holds the stage records and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package pws_pkg;

  localparam int DivSteps    = 32;
  localparam int CordicSteps = 18;
  localparam int ZW          = 22;
  localparam int CW          = 36;

  localparam logic signed [ZW-1:0] AngPi = 22'sd524288;

  // Register index decoded from paddr[3].
  localparam logic REG_DET_THR = 1'b0;

  typedef struct packed {
    logic               solved;
    logic [30:0]        w_xx;
    logic signed [31:0] w_xy;
    logic [30:0]        w_yy;
  } side_t;

  // One division lane: partial remainder and a quotient register that
  // first holds the low numerator bits and shifts quotient bits in.
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [62:0] rem;
    logic [31:0] quo;
  } lane_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    logic [62:0] den;
    lane_t       lx;
    lane_t       ly;
  } div_stage_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
  } sol_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic               zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 22'sd131072;
      5'd1:  v = 22'sd77376;
      5'd2:  v = 22'sd40884;
      5'd3:  v = 22'sd20753;
      5'd4:  v = 22'sd10417;
      5'd5:  v = 22'sd5213;
      5'd6:  v = 22'sd2607;
      5'd7:  v = 22'sd1304;
      5'd8:  v = 22'sd652;
      5'd9:  v = 22'sd326;
      5'd10: v = 22'sd163;
      5'd11: v = 22'sd81;
      5'd12: v = 22'sd41;
      5'd13: v = 22'sd20;
      5'd14: v = 22'sd10;
      5'd15: v = 22'sd5;
      5'd16: v = 22'sd3;
      5'd17: v = 22'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/per_pixel_2x2_weighted_solve.sv =====
// Throughput: one word per cycle; the whole pipeline holds while a result
// waits at the output register, and in_ready is low exactly then.
// Reset (rst_n low, synchronous) clears all stage valid bits and sets the
// determinant threshold to zero.
// ----------------------------------------------------------------------------
// per_pixel_2x2_weighted_solve: per-pixel 2x2 Cramer solve with phase
// Solves the symmetric system when the determinant passes the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module per_pixel_2x2_weighted_solve (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [30:0]        in_mat_xx,
  input  wire logic signed [31:0] in_mat_xy,
  input  wire logic [30:0]        in_mat_yy,
  input  wire logic signed [31:0] in_rhs_x,
  input  wire logic signed [31:0] in_rhs_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_solved,
  output logic signed [31:0]      out_opt_x,
  output logic signed [31:0]      out_opt_y,
  output logic signed [15:0]      out_phase_angle,
  output logic [30:0]             out_weight_xx,
  output logic signed [31:0]      out_weight_xy,
  output logic [30:0]             out_weight_yy
);

  logic                    en;
  logic [61:0]             thr;
  pws_pkg::div_stage_t     front_out;
  pws_pkg::sol_t           div_out;
  pws_pkg::cord_t          cord_out;
  logic signed [pws_pkg::ZW-1:0] zr;

  logic                    out_valid_r;
  logic                    solved_r;
  logic signed [31:0]      opt_x_r, opt_y_r, w_xy_r;
  logic signed [15:0]      phase_r;
  logic [30:0]             w_xx_r, w_yy_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  pws_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  pws_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .mat_xx   (in_mat_xx),
    .mat_xy   (in_mat_xy),
    .mat_yy   (in_mat_yy),
    .rhs_x    (in_rhs_x),
    .rhs_y    (in_rhs_y),
    .thr      (thr),
    .dout     (front_out)
  );

  pws_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (front_out),
    .dout  (div_out)
  );

  pws_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (div_out),
    .dout  (cord_out)
  );

  // Round the angle from pi/2^19 to pi/2^15, half up.
  assign zr = cord_out.z + 22'sd8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cord_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (cord_out.side.solved) begin
        solved_r <= 1'b1;
        opt_x_r  <= cord_out.ox;
        opt_y_r  <= cord_out.oy;
        phase_r  <= cord_out.zero ? 16'sd0 : $signed(zr[19:4]);
        w_xx_r   <= cord_out.side.w_xx;
        w_xy_r   <= cord_out.side.w_xy;
        w_yy_r   <= cord_out.side.w_yy;
      end else begin
        solved_r <= 1'b0;
        opt_x_r  <= '0;
        opt_y_r  <= '0;
        phase_r  <= '0;
        w_xx_r   <= '0;
        w_xy_r   <= '0;
        w_yy_r   <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_solved      = solved_r;
  assign out_opt_x       = opt_x_r;
  assign out_opt_y       = opt_y_r;
  assign out_phase_angle = phase_r;
  assign out_weight_xx   = w_xx_r;
  assign out_weight_xy   = w_xy_r;
  assign out_weight_yy   = w_yy_r;

endmodule

`default_nettype wire

// ===== hdl/pws_cfg.sv =====
// ----------------------------------------------------------------------------
// pws_cfg: configuration register file
// APB-style access to the determinant threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module pws_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output logic [61:0]      thr
);

  logic [61:0] thr_r;

  assign pready = 1'b1;
  assign thr    = thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (psel && penable && pwrite && paddr[3] == pws_pkg::REG_DET_THR) begin
      thr_r <= pwdata[61:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3] == pws_pkg::REG_DET_THR) begin
      prdata = {2'b00, thr_r};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pws_front.sv =====
// ----------------------------------------------------------------------------
// pws_front: products, determinant and numerators
// Six multiplies, then the differences, are registered in turn; magnitudes,
// threshold test and divider setup are combinational on the differences.
// ----------------------------------------------------------------------------
`default_nettype none

module pws_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [30:0]        mat_xx,
  input  wire logic signed [31:0] mat_xy,
  input  wire logic [30:0]        mat_yy,
  input  wire logic signed [31:0] rhs_x,
  input  wire logic signed [31:0] rhs_y,
  input  wire logic [61:0]        thr,
  output pws_pkg::div_stage_t     dout
);

  logic signed [31:0] xx_s, yy_s;
  logic               v1_r, v2_r;
  pws_pkg::side_t     side1_r, side2_r;
  logic signed [63:0] p_xxyy_r, p_xyxy_r, p_bxyy_r, p_xyby_r, p_xxby_r, p_xybx_r;
  logic signed [63:0] det_r, nx_r, ny_r;
  logic [62:0]        adet, nmag_x, nmag_y;

  assign xx_s = {1'b0, mat_xx};
  assign yy_s = {1'b0, mat_yy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xxyy_r       <= xx_s * yy_s;
      p_xyxy_r       <= mat_xy * mat_xy;
      p_bxyy_r       <= rhs_x * yy_s;
      p_xyby_r       <= mat_xy * rhs_y;
      p_xxby_r       <= xx_s * rhs_y;
      p_xybx_r       <= mat_xy * rhs_x;
      side1_r.solved <= 1'b0;
      side1_r.w_xx   <= mat_xx;
      side1_r.w_xy   <= mat_xy;
      side1_r.w_yy   <= mat_yy;
      det_r          <= p_xxyy_r - p_xyxy_r;
      nx_r           <= p_bxyy_r - p_xyby_r;
      ny_r           <= p_xxby_r - p_xybx_r;
      side2_r        <= side1_r;
    end
  end

  // Both numerators stay below 2^63 in magnitude, the determinant at most 2^62.
  assign adet   = det_r[63] ? 63'(-det_r) : det_r[62:0];
  assign nmag_x = nx_r[63]  ? 63'(-nx_r)  : nx_r[62:0];
  assign nmag_y = ny_r[63]  ? 63'(-ny_r)  : ny_r[62:0];

  always_comb begin
    dout             = '0;
    dout.valid       = v2_r;
    dout.side        = side2_r;
    dout.side.solved = adet > {1'b0, thr};
    dout.den         = adet;
    dout.lx.neg      = nx_r[63] ^ det_r[63];
    dout.ly.neg      = ny_r[63] ^ det_r[63];
    // The quotient overflows 32 bits exactly when n >> 16 is at least d.
    dout.lx.ovf      = {16'b0, nmag_x[62:16]} >= adet;
    dout.ly.ovf      = {16'b0, nmag_y[62:16]} >= adet;
    dout.lx.rem      = {16'b0, nmag_x[62:16]};
    dout.ly.rem      = {16'b0, nmag_y[62:16]};
    dout.lx.quo      = {nmag_x[15:0], 16'b0};
    dout.ly.quo      = {nmag_y[15:0], 16'b0};
  end

endmodule

`default_nettype wire

// ===== hdl/pws_div.sv =====
// ----------------------------------------------------------------------------
// pws_div: pipelined restoring divider for both solution components
// One quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module pws_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  pws_pkg::div_stage_t din,
  output pws_pkg::sol_t       dout
);

  localparam int N = pws_pkg::DivSteps;

  pws_pkg::div_stage_t st_r [N];
  pws_pkg::sol_t       sol_r;

  function automatic pws_pkg::lane_t div_step(input pws_pkg::lane_t l, input logic [62:0] d);
    pws_pkg::lane_t o;
    logic [63:0]    r2;
    logic           qb;
    r2 = {l.rem, l.quo[31]};
    qb = r2 >= {1'b0, d};
    if (qb) begin
      r2 = r2 - {1'b0, d};
    end
    o     = l;
    o.rem = r2[62:0];
    o.quo = {l.quo[30:0], qb};
    return o;
  endfunction

  function automatic logic signed [31:0] sat(input pws_pkg::lane_t l);
    logic signed [31:0] v;
    if (l.ovf) begin
      v = l.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (l.neg) begin
      v = (l.quo > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(l.quo);
    end else begin
      v = l.quo[31] ? 32'sh7FFF_FFFF : $signed(l.quo);
    end
    return v;
  endfunction

  for (genvar i = 0; i < N; i++) begin : g_step
    pws_pkg::div_stage_t prev, st_nxt;
    if (i == 0) begin : g_first
      assign prev = din;
    end else begin : g_rest
      assign prev = st_r[i-1];
    end
    always_comb begin
      st_nxt    = prev;
      st_nxt.lx = div_step(prev.lx, prev.den);
      st_nxt.ly = div_step(prev.ly, prev.den);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i].valid <= 1'b0;
      end else if (en) begin
        st_r[i] <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sol_r.valid <= 1'b0;
    end else if (en) begin
      sol_r.valid <= st_r[N-1].valid;
      sol_r.side  <= st_r[N-1].side;
      sol_r.ox    <= sat(st_r[N-1].lx);
      sol_r.oy    <= sat(st_r[N-1].ly);
    end
  end

  assign dout = sol_r;

endmodule

`default_nettype wire

// ===== hdl/pws_cordic.sv =====
// ----------------------------------------------------------------------------
// pws_cordic: pipelined CORDIC vectoring for the phase angle
// Half-plane fold, normalization, then one rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pws_cordic (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  pws_pkg::sol_t  din,
  output pws_pkg::cord_t dout
);

  localparam int N  = pws_pkg::CordicSteps;
  localparam int CW = pws_pkg::CW;

  pws_pkg::cord_t fold_r, norm_r, norm_nxt, fold_nxt;
  pws_pkg::cord_t it_r [N];

  // Left half-plane: negate both and start from pi.
  always_comb begin
    fold_nxt       = '0;
    fold_nxt.valid = din.valid;
    fold_nxt.side  = din.side;
    fold_nxt.ox    = din.ox;
    fold_nxt.oy    = din.oy;
    fold_nxt.zero  = din.ox == 32'sd0;
    if (din.ox < 0) begin
      fold_nxt.x = -CW'(din.ox);
      fold_nxt.y = -CW'(din.oy);
      fold_nxt.z = pws_pkg::AngPi;
    end else begin
      fold_nxt.x = CW'(din.ox);
      fold_nxt.y = CW'(din.oy);
      fold_nxt.z = '0;
    end
  end

  // Shift so that the larger magnitude lands in [2^30, 2^31]. A shift of
  // 2^k is taken when the smaller remaining shifts cannot reach 2^30.
  always_comb begin
    logic [32:0] m, my;
    norm_nxt = fold_r;
    my = fold_r.y[CW-1] ? 33'(-fold_r.y) : fold_r.y[32:0];
    m  = (fold_r.x[32:0] > my) ? fold_r.x[32:0] : my;
    for (int k = 4; k >= 0; k--) begin
      if (m < (33'd1 << (31 - (1 << k)))) begin
        m          = m << (1 << k);
        norm_nxt.x = norm_nxt.x <<< (1 << k);
        norm_nxt.y = norm_nxt.y <<< (1 << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r.valid <= 1'b0;
      norm_r.valid <= 1'b0;
    end else if (en) begin
      fold_r <= fold_nxt;
      norm_r <= norm_nxt;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    pws_pkg::cord_t prev, it_nxt;
    if (i == 0) begin : g_first
      assign prev = norm_r;
    end else begin : g_rest
      assign prev = it_r[i-1];
    end
    always_comb begin
      logic signed [CW-1:0] xs, ys;
      xs     = prev.x >>> i;
      ys     = prev.y >>> i;
      it_nxt = prev;
      if (!prev.y[CW-1]) begin
        it_nxt.x = prev.x + ys;
        it_nxt.y = prev.y - xs;
        it_nxt.z = prev.z + pws_pkg::atan_val(5'(i));
      end else begin
        it_nxt.x = prev.x - ys;
        it_nxt.y = prev.y + xs;
        it_nxt.z = prev.z - pws_pkg::atan_val(5'(i));
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_r[i].valid <= 1'b0;
      end else if (en) begin
        it_r[i] <= it_nxt;
      end
    end
  end

  assign dout = it_r[N-1];

endmodule

`default_nettype wire

// ===== hdl/pws_checker.sv =====
// ----------------------------------------------------------------------------
// pws_checker: port-level checks for the weighted solve block
// Bound to the top level; watches handshakes and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module pws_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_solved,
  input wire logic signed [31:0] out_opt_x,
  input wire logic signed [31:0] out_opt_y,
  input wire logic signed [15:0] out_phase_angle,
  input wire logic [30:0]        out_weight_xx,
  input wire logic signed [31:0] out_weight_xy,
  input wire logic [30:0]        out_weight_yy
);

  // A stalled result keeps out_valid and both solution components on the port.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_opt_x) && $stable(out_opt_y))
    else $error("result word changed while stalled");

  // Input ready is high exactly when the output register can move, as the pipeline advances.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_unsolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_solved |-> out_opt_x == 0 && out_opt_y == 0 &&
      out_phase_angle == 0 && out_weight_xx == 0 && out_weight_xy == 0 &&
      out_weight_yy == 0)
    else $error("unsolved word carries nonzero fields");

  a_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_opt_x == 0 |-> out_phase_angle == 0)
    else $error("phase nonzero with zero x component");

endmodule

bind per_pixel_2x2_weighted_solve pws_checker u_pws_checker (.*);

`default_nettype wire
